@@ hdl/uart_register_frame_sequencer_top_defines.svh @@
// assertion macros shared by the uart register frame sequencer rtl
// no dependencies; included by files that carry concurrent checks
`ifndef UART_REGISTER_FRAME_SEQUENCER_TOP_DEFINES_SVH
`define UART_REGISTER_FRAME_SEQUENCER_TOP_DEFINES_SVH

`ifndef SYNTHESIS

`define URFS_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("urfs check failed");

`define URFS_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("urfs check failed");

`else

`define URFS_ASSERT_IMPL(label, clk, rstn, ante, cons)

`define URFS_ASSERT_NEXT(label, clk, rstn, ante, cons)

`endif

`endif

@@ hdl/urfs_pkg.sv @@
// types, frame constants and step tables for the uart register frame sequencer
// no dependencies
package urfs_pkg;

    localparam int unsigned STEP_W  = 5;
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned ADDR_W  = 16;
    localparam int unsigned DATA_W  = 24;
    localparam int unsigned KIND_W  = 3;
    localparam int unsigned S_TDATA_W = 48;
    localparam int unsigned M_TDATA_W = 16;

    localparam logic [BYTE_W-1:0] CMD_WRITE = 8'hCA;
    localparam logic [BYTE_W-1:0] CMD_READ  = 8'h35;
    localparam logic [BYTE_W-1:0] BYTE_MASK = 8'hFF;

    localparam logic [STEP_W-1:0] FINAL_WRITE8  = 5'h0E;
    localparam logic [STEP_W-1:0] FINAL_WRITE16 = 5'h0F;
    localparam logic [STEP_W-1:0] FINAL_WRITE24 = 5'h11;
    localparam logic [STEP_W-1:0] FINAL_READ8   = 5'h0D;
    localparam logic [STEP_W-1:0] FINAL_READ16  = 5'h10;
    localparam logic [STEP_W-1:0] FINAL_READ24  = 5'h13;

    localparam logic [STEP_W-1:0] LAST_WRITE8  = 5'd6;
    localparam logic [STEP_W-1:0] LAST_WRITE16 = 5'd8;
    localparam logic [STEP_W-1:0] LAST_WRITE24 = 5'd10;
    localparam logic [STEP_W-1:0] LAST_READ    = 5'd4;

    typedef enum logic [KIND_W-1:0] {
        KIND_WRITE8  = 3'd0,
        KIND_WRITE16 = 3'd1,
        KIND_WRITE24 = 3'd2,
        KIND_READ8   = 3'd3,
        KIND_READ16  = 3'd4,
        KIND_READ24  = 3'd5
    } kind_t;

    typedef struct packed {
        logic                tx_ready;
        logic [DATA_W-1:0]   write_data;
        logic [ADDR_W-1:0]   reg_address;
        logic [KIND_W-1:0]   action;
    } item_t;

    typedef struct packed {
        logic                frame_ok;
        logic                frame_done;
        logic [BYTE_W-1:0]   tx_byte;
        logic                tx_valid;
    } result_t;

    typedef struct packed {
        logic load;
        logic advance;
    } stage_ctl_t;

    function automatic logic [STEP_W-1:0] last_byte_step(input logic [KIND_W-1:0] kind);
        logic [STEP_W-1:0] r;
        unique case (kind)
            KIND_WRITE8:  r = LAST_WRITE8;
            KIND_WRITE16: r = LAST_WRITE16;
            KIND_WRITE24: r = LAST_WRITE24;
            default:      r = LAST_READ;
        endcase
        return r;
    endfunction

    function automatic logic [STEP_W-1:0] final_step(input logic [KIND_W-1:0] kind);
        logic [STEP_W-1:0] r;
        unique case (kind)
            KIND_WRITE8:  r = FINAL_WRITE8;
            KIND_WRITE16: r = FINAL_WRITE16;
            KIND_WRITE24: r = FINAL_WRITE24;
            KIND_READ8:   r = FINAL_READ8;
            KIND_READ16:  r = FINAL_READ16;
            default:      r = FINAL_READ24;
        endcase
        return r;
    endfunction

endpackage

@@ hdl/urfs_step.sv @@
// step counter, ok flag and frame byte select for one tick
// depends on urfs_pkg and the shared assertion macros
`include "uart_register_frame_sequencer_top_defines.svh"

module urfs_step (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             fire,
    input  urfs_pkg::item_t  item,
    output urfs_pkg::result_t res
);
    import urfs_pkg::*;

    logic [STEP_W-1:0] step_count_reg, step_count_next;
    logic              sent_ok_reg, sent_ok_next;
    logic [STEP_W-1:0] last_step;
    logic [STEP_W-1:0] done_step;
    logic [BYTE_W-1:0] frame_byte;
    logic              is_write;
    logic              kind_ok;

    assign kind_ok   = item.action <= KIND_READ24;
    assign is_write  = item.action < KIND_READ8;
    assign last_step = last_byte_step(item.action);
    assign done_step = final_step(item.action);

    always_comb begin
        unique case (step_count_reg[STEP_W-1:1])
            4'd0:    frame_byte = is_write ? CMD_WRITE : CMD_READ;
            4'd1:    frame_byte = item.reg_address[15:8];
            4'd2:    frame_byte = item.reg_address[7:0] & BYTE_MASK;
            4'd3:    frame_byte = item.write_data[7:0];
            4'd4:    frame_byte = item.write_data[15:8];
            default: frame_byte = item.write_data[23:16];
        endcase
    end

    always_comb begin
        step_count_next = step_count_reg;
        sent_ok_next    = sent_ok_reg;
        res             = '0;
        if (kind_ok) begin
            priority if (step_count_reg == done_step) begin
                step_count_next = '0;
                res.frame_done  = 1'b1;
                res.frame_ok    = (item.action == KIND_WRITE16 || item.action == KIND_WRITE24)
                                  ? 1'b1 : sent_ok_reg;
            end else if (!step_count_reg[0] && step_count_reg <= last_step) begin
                priority if (item.tx_ready) begin
                    res.tx_valid    = 1'b1;
                    res.tx_byte     = frame_byte;
                    if (step_count_reg == last_step) begin
                        sent_ok_next = 1'b1;
                    end
                    step_count_next = step_count_reg + 1'b1;
                end else if (step_count_reg == last_step) begin
                    if (!is_write) begin
                        sent_ok_next = 1'b0;
                    end
                end else begin
                    sent_ok_next    = 1'b0;
                    step_count_next = last_step + 1'b1;
                end
            end else begin
                step_count_next = step_count_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_count_reg <= '0;
            sent_ok_reg    <= 1'b1;
        end else if (fire) begin
            step_count_reg <= step_count_next;
            sent_ok_reg    <= sent_ok_next;
        end
    end

    `URFS_ASSERT_NEXT(a_done_restarts, aclk, aresetn, fire && res.frame_done, step_count_reg == '0)
    `URFS_ASSERT_NEXT(a_idle_holds, aclk, aresetn, !fire,
        $stable(step_count_reg) && $stable(sent_ok_reg))
    `URFS_ASSERT_IMPL(a_byte_or_done, aclk, aresetn, res.tx_valid, !res.frame_done)
    `URFS_ASSERT_IMPL(a_byte_on_even, aclk, aresetn, res.tx_valid, !step_count_reg[0])

endmodule

@@ hdl/urfs_out_reg.sv @@
// result register feeding the master side of the stream
// depends on urfs_pkg
module urfs_out_reg (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         load,
    input  urfs_pkg::result_t            res,
    output logic                         advance,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [urfs_pkg::M_TDATA_W-1:0] m_tdata,
    output logic                         m_tlast
);
    import urfs_pkg::*;

    logic    out_valid_reg;
    result_t out_res_reg;

    assign advance  = !out_valid_reg || m_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, out_res_reg.frame_ok, out_res_reg.tx_byte, out_res_reg.tx_valid};
    assign m_tlast  = out_res_reg.frame_done;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= load;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && load) begin
            out_res_reg <= res;
        end
    end

endmodule

@@ hdl/uart_register_frame_sequencer_top.sv @@
// Frame sequencer for register access over a uart link. Each request on the
// slave side is one tick and yields exactly one result request on the master
// side, in order. The block takes one request every cycle while the master
// side keeps up. A request first waits in the input register, then the
// one-step state update fills the result register, which presents the result
// on the master side; a master-side stall holds both. The step counter and ok
// flag advance once per tick, which sets the one-tick-per-cycle rate while
// the master side keeps up.
// depends on urfs_pkg, urfs_step and urfs_out_reg
module uart_register_frame_sequencer_top (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // action[2:0], reg_address[18:3], write_data[42:19], tx_ready[43], zero pad
    input  logic [urfs_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // tx_valid[0], tx_byte[8:1], frame_ok[9], zero pad
    output logic [urfs_pkg::M_TDATA_W-1:0] m_tdata,
    // frame_done
    output logic                          m_tlast
);
    import urfs_pkg::*;

    logic       in_valid_reg;
    item_t      in_item_reg;
    stage_ctl_t ctl;
    result_t    step_res;

    assign ctl.load = in_valid_reg;
    assign s_tready = !in_valid_reg || ctl.advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_item_reg <= item_t'(s_tdata[$bits(item_t)-1:0]);
        end
    end

    urfs_step u_step (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (ctl.load && ctl.advance),
        .item    (in_item_reg),
        .res     (step_res)
    );

    urfs_out_reg u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (ctl.load),
        .res      (step_res),
        .advance  (ctl.advance),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

@@ tb/urfs_frame_checker.sv @@
// checker for the uart register frame sequencer: watches both stream channels,
// predicts each tick's result from its own step counter and ok flag, compares
// depends on urfs_pkg
module urfs_frame_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [urfs_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [urfs_pkg::M_TDATA_W-1:0] m_tdata,
    input  logic                           m_tlast,
    output int                             fail_count,
    output int                             pending,
    output logic                           frame_start
);
    import urfs_pkg::*;

    logic [STEP_W-1:0] step_q;
    logic              sent_ok_q;
    result_t           tick_results_q[$];
    result_t           got;
    result_t           want;
    result_t           tick_res;
    item_t             tick_in;

    initial begin
        fail_count  = 0;
        pending     = 0;
        frame_start = 1'b1;
        step_q      = '0;
        sent_ok_q   = 1'b1;
    end

    task automatic sequence_tick(input item_t it, output result_t r);
        logic [STEP_W-1:0] s;
        logic [STEP_W-1:0] last;
        logic [STEP_W-1:0] fin;
        r = '0;
        s = step_q;
        if (it.action <= KIND_READ24) begin
            case (it.action)
                KIND_WRITE8: begin
                    last = LAST_WRITE8;
                    fin  = FINAL_WRITE8;
                end
                KIND_WRITE16: begin
                    last = LAST_WRITE16;
                    fin  = FINAL_WRITE16;
                end
                KIND_WRITE24: begin
                    last = LAST_WRITE24;
                    fin  = FINAL_WRITE24;
                end
                KIND_READ8: begin
                    last = LAST_READ;
                    fin  = FINAL_READ8;
                end
                KIND_READ16: begin
                    last = LAST_READ;
                    fin  = FINAL_READ16;
                end
                default: begin
                    last = LAST_READ;
                    fin  = FINAL_READ24;
                end
            endcase
            if (s == fin) begin
                step_q       = '0;
                r.frame_done = 1'b1;
                r.frame_ok   = (it.action == KIND_WRITE16 || it.action == KIND_WRITE24)
                               ? 1'b1 : sent_ok_q;
            end else if (!s[0] && s <= last) begin
                if (it.tx_ready) begin
                    r.tx_valid = 1'b1;
                    case (s[4:1])
                        0: r.tx_byte = (it.action < KIND_READ8) ? CMD_WRITE : CMD_READ;
                        1: r.tx_byte = it.reg_address[15:8];
                        2: r.tx_byte = it.reg_address[7:0];
                        3: r.tx_byte = it.write_data[7:0];
                        4: r.tx_byte = it.write_data[15:8];
                        default: r.tx_byte = it.write_data[23:16];
                    endcase
                    if (s == last) sent_ok_q = 1'b1;
                    step_q = s + 1'b1;
                end else if (s == last) begin
                    if (it.action >= KIND_READ8) sent_ok_q = 1'b0;
                end else begin
                    sent_ok_q = 1'b0;
                    step_q    = last + 1'b1;
                end
            end else begin
                step_q = s + 1'b1;
            end
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            step_q    = '0;
            sent_ok_q = 1'b1;
            tick_results_q.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                got.tx_valid   = m_tdata[0];
                got.tx_byte    = m_tdata[8:1];
                got.frame_ok   = m_tdata[9];
                got.frame_done = m_tlast;
                if (tick_results_q.size() == 0) begin
                    if (fail_count < 10)
                        $display("unexpected result: valid %0b byte %02h done %0b ok %0b",
                                 got.tx_valid, got.tx_byte, got.frame_done, got.frame_ok);
                    fail_count++;
                end else begin
                    want = tick_results_q.pop_front();
                    if (got !== want) begin
                        if (fail_count < 10)
                            $display({"mismatch: expected valid %0b byte %02h done %0b ok %0b,",
                                      " got valid %0b byte %02h done %0b ok %0b"},
                                     want.tx_valid, want.tx_byte, want.frame_done,
                                     want.frame_ok, got.tx_valid, got.tx_byte,
                                     got.frame_done, got.frame_ok);
                        fail_count++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                tick_in = s_tdata[$bits(item_t)-1:0];
                sequence_tick(tick_in, tick_res);
                tick_results_q.push_back(tick_res);
            end
        end
        pending     = tick_results_q.size();
        frame_start = (step_q == '0);
    end

endmodule

@@ tb/uart_register_frame_sequencer_top_test.sv @@
// testbench top for the uart register frame sequencer: clock, reset, tick
// stimulus with random idling on both channels, and the final verdict
// depends on urfs_pkg, uart_register_frame_sequencer_top and urfs_frame_checker
module uart_register_frame_sequencer_top_test;
    import urfs_pkg::*;

    localparam int ITEMS       = 440;
    localparam int QUIET_AT    = 390;
    localparam int HOLD_AT     = 150;
    localparam int PAUSE_AT    = 300;
    localparam int HOLD_CYCLES = 300;
    localparam int LIMIT       = 200000;

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tlast;

    int          fail_count;
    int          pending;
    logic        frame_start;
    int          tick_count = 0;
    int          gap_odds = 0;
    bit          quiet = 1'b0;
    bit          hold_req = 1'b0;
    bit          hold_done = 1'b0;
    int unsigned cycle_count = 0;

    always #1 aclk = ~aclk;

    uart_register_frame_sequencer_top uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    urfs_frame_checker frame_watch (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .fail_count  (fail_count),
        .pending     (pending),
        .frame_start (frame_start)
    );

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // result side: random stalls, one long hold-off, always ready at the end
    initial begin
        m_tready = 1'b0;
        forever begin
            if (hold_req && !hold_done) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_done = 1'b1;
            end else if (quiet) begin
                m_tready <= 1'b1;
                @(negedge aclk);
            end else begin
                m_tready <= ($urandom_range(0, 3) != 0);
                repeat ($urandom_range(1, 15)) @(negedge aclk);
            end
        end
    end

    function automatic logic [23:0] field_value(input int w);
        logic [23:0] v;
        case ($urandom_range(0, 5))
            0: v = '0;
            1: v = '1;
            default: v = 24'($urandom);
        endcase
        return v & ((24'd1 << w) - 24'd1);
    endfunction

    task automatic put_tick(input logic [KIND_W-1:0] kind, input logic [ADDR_W-1:0] addr,
                            input logic [DATA_W-1:0] data, input logic ready);
        item_t it;
        if (!quiet && gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge aclk);
        end
        it.action      = kind;
        it.reg_address = addr;
        it.write_data  = data;
        it.tx_ready    = ready;
        s_tvalid <= 1'b1;
        s_tdata  <= S_TDATA_W'(it);
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
        tick_count++;
        if (tick_count >= QUIET_AT) quiet = 1'b1;
        if (tick_count >= HOLD_AT) hold_req = 1'b1;
    endtask

    // keeps the frame kind until the sequencer is back at step 0 or the cap is reached
    task automatic frame_ticks(input logic [KIND_W-1:0] kind, input logic [ADDR_W-1:0] addr,
                               input logic [DATA_W-1:0] data, input int miss_odds,
                               input int cap);
        int n;
        n = 0;
        do begin
            put_tick(kind, addr, data, miss_odds == 0 || $urandom_range(1, miss_odds) != 1);
            n++;
        end while (!frame_start && n < cap);
    endtask

    initial begin
        logic [KIND_W-1:0] kind;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] data;
        int                pick;
        int                odds;
        bit                paused;
        paused   = 1'b0;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // unused action codes, then a full write8 and a read8 losing its first byte
        put_tick(3'd7, 16'hFFFF, 24'hFFFFFF, 1'b1);
        put_tick(3'd6, 16'hFFFF, 24'hFFFFFF, 1'b0);
        frame_ticks(KIND_WRITE8, 16'hFFFF, 24'hFFFFFF, 0, 40);
        put_tick(KIND_READ8, 16'h0000, 24'h000000, 1'b0);
        frame_ticks(KIND_READ8, 16'h0000, 24'h000000, 0, 40);

        while (tick_count < ITEMS) begin
            gap_odds = ($urandom_range(0, 2) == 0) ? 0 : 6;
            pick = $urandom_range(0, 9);
            kind = 3'($urandom_range(0, 5));
            addr = ADDR_W'(field_value(ADDR_W));
            data = field_value(DATA_W);
            case ($urandom_range(0, 3))
                0: odds = 0;
                3: odds = 2;
                default: odds = 6;
            endcase
            if (pick < 8) begin
                frame_ticks(kind, addr, data, odds, 48);
            end else if (pick == 8) begin
                repeat ($urandom_range(1, 6))
                    put_tick(3'($urandom_range(0, 7)), 16'($urandom), 24'($urandom),
                             1'($urandom_range(0, 1)));
            end else begin
                // kind changes in the middle of a frame
                repeat ($urandom_range(1, 18))
                    put_tick(kind, addr, data, odds == 0 || $urandom_range(1, odds) != 1);
                frame_ticks(3'($urandom_range(0, 5)), addr, data, odds, 48);
            end
            if (!paused && tick_count >= PAUSE_AT) begin
                paused = 1'b1;
                s_tvalid <= 1'b0;
                do @(negedge aclk); while (pending != 0);
            end
        end

        s_tvalid <= 1'b0;
        do @(negedge aclk); while (pending != 0);
        repeat (8) @(negedge aclk);
        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
